@@ hdl/pop3rp_pkg.sv @@
// Shared types, codes and helpers for the mail-retrieval response parser.
`timescale 1ns / 1ps
`default_nettype none

package pop3rp_pkg;

  localparam int SLEN_W         = 10;
  localparam int MAX_STATUS_LEN = 512;
  localparam logic [SLEN_W-1:0] STATUS_LEN_MAX = SLEN_W'(MAX_STATUS_LEN);

  typedef enum logic [1:0] {
    PH_STATUS,
    PH_BODY,
    PH_DRAIN
  } phase_t;

  // result kinds
  localparam logic [2:0] KIND_STATUS = 3'd0;
  localparam logic [2:0] KIND_SIZE   = 3'd1;
  localparam logic [2:0] KIND_IDBYTE = 3'd2;
  localparam logic [2:0] KIND_IDEND  = 3'd3;
  localparam logic [2:0] KIND_MSG    = 3'd4;
  localparam logic [2:0] KIND_ERR    = 3'd5;

  // response modes
  localparam logic [2:0] MODE_STATUS = 3'd0;
  localparam logic [2:0] MODE_COUNT  = 3'd1;
  localparam logic [2:0] MODE_SIZE   = 3'd2;
  localparam logic [2:0] MODE_ID     = 3'd3;
  localparam logic [2:0] MODE_MSG    = 3'd4;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // largest accumulator value that can still take another digit
  localparam logic [31:0] ACC_LIMIT = 32'd429496729;

  typedef struct packed {
    phase_t              phase;
    logic [SLEN_W-1:0]   status_length;
    logic [31:0]         number_acc;
    logic [1:0]          field_pos;
    logic                cr_seen;
    logic [1:0]          held_bytes;
    logic                pos_status;
    logic                line_start;
    logic                dot_line;
  } parse_st_t;

  localparam parse_st_t ST_RESET = '{
    phase:         PH_STATUS,
    status_length: '0,
    number_acc:    '0,
    field_pos:     '0,
    cr_seen:       1'b0,
    held_bytes:    '0,
    pos_status:    1'b0,
    line_start:    1'b1,
    dot_line:      1'b0
  };

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] value;
    logic        status_ok;
    logic        last;
  } result_t;

  function automatic result_t make_res(input logic [2:0] kind, input logic [31:0] value,
                                       input logic ok, input logic last);
    result_t r;
    r.kind      = kind;
    r.value     = value;
    r.status_ok = ok;
    r.last      = last;
    return r;
  endfunction

  function automatic parse_st_t clear_line(input parse_st_t s);
    parse_st_t r;
    r            = s;
    r.number_acc = '0;
    r.field_pos  = '0;
    r.cr_seen    = 1'b0;
    r.held_bytes = '0;
    r.line_start = 1'b1;
    r.dot_line   = 1'b0;
    return r;
  endfunction

  // {ok, acc*10 + digit}, or {0, acc} on a non-digit or on overflow
  function automatic logic [32:0] add_digit(input logic [31:0] acc, input logic [7:0] c);
    logic [3:0]  d;
    logic        ok;
    logic [31:0] nxt;
    d   = 4'(c - CH_ZERO);
    ok  = (c >= CH_ZERO) && (c <= CH_NINE) &&
          !((acc > ACC_LIMIT) || ((acc == ACC_LIMIT) && (d > 4'd5)));
    nxt = (acc << 3) + (acc << 1) + {28'b0, d};
    return {ok, ok ? nxt : acc};
  endfunction

endpackage

`default_nettype wire

@@ hdl/pop3_response_parser.sv @@
// Byte-stream parser for mail-retrieval server replies, with a four-entry result queue.
`timescale 1ns / 1ps
`default_nettype none

// Takes one response byte per cycle on the slave stream and reports status, list sizes,
// id bytes/ends, message bytes and protocol errors on the master stream. Each byte is
// parsed by single-pass logic from the parser state register into a four-entry result
// queue, which stores each result as its byte is taken. s_tready is high while the
// queue holds at most one result, so a byte giving one result or none is taken every
// cycle while m_tready is high, even with a result waiting. A byte that gives two or
// three results (a '.' held at a message line start that turns out not to close the
// body, or a byte after a lone CR in an id list line) holds off input until the queue
// drains to one result, one result per cycle while m_tready is high. Writing cfg_data
// sets response_mode (0 status, 1 status with count, 2 size list, 3 id list, 4 message
// body; 5..7 as 0) and returns the parser to waiting for a status line.
module pop3_response_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_data,     // response_mode
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,      // [7:0] rx_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,      // [31:0] value, [32] status_ok, [39:33] zero
  output logic [2:0]       m_tuser,      // [2:0] kind
  output logic             m_tlast       // last result of the response
);
  import pop3rp_pkg::*;

  logic [2:0]  mode;
  parse_st_t   st, st_next;
  result_t     res [3];
  logic [1:0]  res_n;

  result_t     fifo [4];
  logic [1:0]  wr_ptr, rd_ptr;
  logic [2:0]  count;
  logic        in_accept, out_accept;
  logic [2:0]  push_n;

  assign cfg_ready  = 1'b1;
  assign s_tready   = (count <= 3'd1);
  assign in_accept  = s_tvalid && s_tready;
  assign m_tvalid   = (count != 3'd0);
  assign out_accept = m_tvalid && m_tready;
  assign push_n     = in_accept ? {1'b0, res_n} : 3'd0;

  assign m_tuser = fifo[rd_ptr].kind;
  assign m_tdata = {7'b0, fifo[rd_ptr].status_ok, fifo[rd_ptr].value};
  assign m_tlast = fifo[rd_ptr].last;

  always_comb begin
    parse_st_t   s;
    logic [2:0]  m;
    logic [7:0]  b, c;
    logic [1:0]  n;
    logic        run0, failed, fail_p0, ok, more, saved_cr, stop;
    logic [32:0] dig;
    s        = st;
    b        = s_tdata;
    m        = (mode > MODE_MSG) ? MODE_STATUS : mode;
    n        = '0;
    c        = '0;
    run0     = 1'b0;
    failed   = 1'b0;
    fail_p0  = 1'b0;
    ok       = 1'b1;
    more     = 1'b0;
    saved_cr = 1'b0;
    stop     = 1'b0;
    dig      = '0;
    for (int i = 0; i < 3; i++) begin
      res[i] = '0;
    end

    unique case (s.phase)
      PH_STATUS: begin
        s.status_length = s.status_length + 1'b1;
        if (s.status_length == SLEN_W'(1)) s.pos_status = (b == CH_PLUS);
        if (s.cr_seen && b == CH_LF) begin
          if (m == MODE_COUNT && s.pos_status && s.field_pos == 2'd0) begin
            res[n] = make_res(KIND_ERR, '0, s.pos_status, 1'b1);
            n = n + 2'd1;
            s = ST_RESET;
          end else begin
            more = s.pos_status && (m >= MODE_SIZE);
            res[n] = make_res(KIND_STATUS,
                              (m == MODE_COUNT && s.pos_status) ? s.number_acc : 32'd0,
                              s.pos_status, !more);
            n = n + 2'd1;
            s = ST_RESET;
            if (more) begin
              s.pos_status = 1'b1;
              s.phase      = PH_BODY;
            end
          end
        end else begin
          // a pending CR that was not part of CR LF is an ordinary byte first
          run0      = s.cr_seen;
          s.cr_seen = 1'b0;
          for (int p = 0; p < 2; p++) begin
            if (!failed && ((p == 0) ? run0 : (b != CH_CR))) begin
              c  = (p == 0) ? CH_CR : b;
              ok = 1'b1;
              if (m == MODE_COUNT && s.pos_status) begin
                if (s.field_pos == 2'd0) begin
                  if (c == CH_SPACE) s.field_pos = 2'd1;
                end else if (s.field_pos == 2'd1) begin
                  if (c == CH_SPACE) begin
                    s.field_pos = 2'd2;
                  end else begin
                    dig          = add_digit(s.number_acc, c);
                    ok           = dig[32];
                    s.number_acc = dig[31:0];
                  end
                end
              end
              if (!ok) begin
                failed  = 1'b1;
                fail_p0 = (p == 0);
              end
            end
          end
          if (failed) begin
            res[n] = make_res(KIND_ERR, '0, s.pos_status, 1'b1);
            n = n + 2'd1;
            s = ST_RESET;
            s.phase   = PH_DRAIN;
            s.cr_seen = fail_p0 && (b == CH_CR);
          end else begin
            if (b == CH_CR) s.cr_seen = 1'b1;
            if (s.status_length >= STATUS_LEN_MAX) begin
              saved_cr = s.cr_seen;
              res[n] = make_res(KIND_ERR, '0, s.pos_status, 1'b1);
              n = n + 2'd1;
              s = ST_RESET;
              s.phase   = PH_DRAIN;
              s.cr_seen = saved_cr;
            end
          end
        end
      end

      PH_DRAIN: begin
        if (s.cr_seen && b == CH_LF) s = ST_RESET;
        else s.cr_seen = (b == CH_CR);
      end

      PH_BODY: begin
        if (m == MODE_SIZE || m == MODE_ID) begin
          if (s.cr_seen && b == CH_LF) begin
            if (s.dot_line) begin
              res[n] = make_res(KIND_STATUS, '0, s.pos_status, 1'b1);
              n = n + 2'd1;
              s = ST_RESET;
            end else if (s.field_pos == 2'd0) begin
              res[n] = make_res(KIND_ERR, '0, s.pos_status, 1'b1);
              n = n + 2'd1;
              s = ST_RESET;
            end else begin
              if (m == MODE_SIZE) res[n] = make_res(KIND_SIZE, s.number_acc, s.pos_status, 1'b0);
              else res[n] = make_res(KIND_IDEND, '0, s.pos_status, 1'b0);
              n = n + 2'd1;
              s = clear_line(s);
            end
          end else begin
            run0      = s.cr_seen;
            s.cr_seen = 1'b0;
            for (int p = 0; p < 2; p++) begin
              if (!failed && ((p == 0) ? run0 : (b != CH_CR))) begin
                c  = (p == 0) ? CH_CR : b;
                ok = 1'b1;
                if (s.line_start && c == CH_DOT) begin
                  s.dot_line = 1'b1;
                end else if (s.dot_line) begin
                  ok = 1'b0;
                end else if (s.field_pos == 2'd0) begin
                  if (c == CH_SPACE) s.field_pos = 2'd1;
                end else if (m == MODE_SIZE) begin
                  dig          = add_digit(s.number_acc, c);
                  ok           = dig[32];
                  s.number_acc = dig[31:0];
                end else begin
                  res[n] = make_res(KIND_IDBYTE, {24'b0, c}, s.pos_status, 1'b0);
                  n = n + 2'd1;
                end
                if (!ok) begin
                  failed  = 1'b1;
                  fail_p0 = (p == 0);
                end
              end
            end
            if (failed) begin
              res[n] = make_res(KIND_ERR, '0, s.pos_status, 1'b1);
              n = n + 2'd1;
              s = ST_RESET;
              s.phase   = PH_DRAIN;
              s.cr_seen = fail_p0 && (b == CH_CR);
            end else begin
              if (b == CH_CR) s.cr_seen = 1'b1;
              s.line_start = 1'b0;
            end
          end
        end else if (m == MODE_MSG) begin
          // '.' at line start is held until CR LF (end of body) or anything else
          if (s.held_bytes == 2'd1) begin
            if (b == CH_CR) begin
              s.held_bytes = 2'd2;
              stop = 1'b1;
            end else begin
              res[n] = make_res(KIND_MSG, {24'b0, CH_DOT}, s.pos_status, 1'b0);
              n = n + 2'd1;
              s.held_bytes = '0;
              s.dot_line   = 1'b0;
            end
          end else if (s.held_bytes == 2'd2) begin
            if (b == CH_LF) begin
              res[n] = make_res(KIND_STATUS, '0, s.pos_status, 1'b1);
              n = n + 2'd1;
              s = ST_RESET;
              stop = 1'b1;
            end else begin
              res[n] = make_res(KIND_MSG, {24'b0, CH_DOT}, s.pos_status, 1'b0);
              n = n + 2'd1;
              res[n] = make_res(KIND_MSG, {24'b0, CH_CR}, s.pos_status, 1'b0);
              n = n + 2'd1;
              s.held_bytes = '0;
              s.dot_line   = 1'b0;
              s.cr_seen    = 1'b0;
            end
          end else if (s.line_start && b == CH_DOT) begin
            s.held_bytes = 2'd1;
            s.dot_line   = 1'b1;
            s.line_start = 1'b0;
            stop = 1'b1;
          end
          if (!stop) begin
            res[n] = make_res(KIND_MSG, {24'b0, b}, s.pos_status, 1'b0);
            n = n + 2'd1;
            if (s.cr_seen && b == CH_LF) begin
              s.cr_seen    = 1'b0;
              s.line_start = 1'b1;
            end else begin
              s.cr_seen    = (b == CH_CR);
              s.line_start = 1'b0;
            end
          end
        end else begin
          s = ST_RESET;
        end
      end

      default: begin
        s = ST_RESET;
      end
    endcase

    st_next = s;
    res_n   = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_STATUS;
      st     <= ST_RESET;
      count  <= '0;
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (cfg_valid) begin
        mode <= cfg_data;
        st   <= ST_RESET;
      end else if (in_accept) begin
        st <= st_next;
      end
      wr_ptr <= wr_ptr + push_n[1:0];
      if (out_accept) rd_ptr <= rd_ptr + 2'd1;
      count <= count + push_n - {2'b0, out_accept};
    end
  end

  // result queue storage
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (in_accept && (2'(i) < res_n)) fifo[wr_ptr + 2'(i)] <= res[i];
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 3'd4)
    else $error("result queue overfilled");

  a_push_visible: assert property (@(posedge clk) disable iff (rst)
    (in_accept && res_n != 2'd0) |=> m_tvalid)
    else $error("pushed result not presented");

  a_held_in_msg: assert property (@(posedge clk) disable iff (rst)
    (st.held_bytes != 2'd0) |-> (st.phase == PH_BODY && mode == MODE_MSG))
    else $error("held dot outside message body");

  a_status_len: assert property (@(posedge clk) disable iff (rst)
    (st.phase == PH_STATUS) |-> (st.status_length < STATUS_LEN_MAX))
    else $error("status length passed its limit");

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
// Self-checking testbench for the mail-retrieval response parser.
`timescale 1ns / 1ps

module tb_top;
  import pop3rp_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_data = MODE_STATUS;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;     // [7:0] rx_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;             // [31:0] value, [32] status_ok, [39:33] zero
  logic [2:0]  m_tuser;             // [2:0] kind
  logic        m_tlast;

  pop3_response_parser i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Parser prediction
  // ---------------------------------------------------------------------------
  logic [2:0]  mode_reg;
  phase_t      ph;
  logic [9:0]  slen;
  logic [31:0] acc;
  logic [1:0]  fpos;
  bit          cr;
  logic [1:0]  held;
  bit          pos;
  bit          lstart;
  bit          dotl;

  result_t     pending_results[$];

  function automatic void clear_line_st();
    acc    = '0;
    fpos   = '0;
    cr     = 1'b0;
    held   = '0;
    lstart = 1'b1;
    dotl   = 1'b0;
  endfunction

  function automatic void clear_all_st();
    ph   = PH_STATUS;
    slen = '0;
    pos  = 1'b0;
    clear_line_st();
  endfunction

  function automatic void add_result(logic [2:0] k, logic [31:0] v, bit lst);
    result_t r;
    r.kind      = k;
    r.value     = v;
    r.status_ok = pos;
    r.last      = lst;
    pending_results.insert(pending_results.size(), r);
  endfunction

  // error result; when the line is still open the rest of it is dropped
  function automatic void flag_error(bit line_ended);
    bit keep_cr;
    keep_cr = cr;
    add_result(KIND_ERR, '0, 1'b1);
    clear_all_st();
    if (!line_ended) begin
      ph = PH_DRAIN;
      cr = keep_cr;
    end
  endfunction

  function automatic logic [2:0] eff_mode();
    return (mode_reg > MODE_MSG) ? MODE_STATUS : mode_reg;
  endfunction

  function automatic bit push_digit(logic [7:0] c);
    logic [31:0] d;
    if (c < CH_ZERO || c > CH_NINE) return 1'b0;
    d = {24'b0, c - CH_ZERO};
    if (acc > ACC_LIMIT || (acc == ACC_LIMIT && d > 32'd5)) return 1'b0;
    acc = acc * 32'd10 + d;
    return 1'b1;
  endfunction

  function automatic bit status_char(logic [7:0] c);
    if (eff_mode() != MODE_COUNT || !pos) return 1'b1;
    if (fpos == 2'd0) begin
      if (c == CH_SPACE) fpos = 2'd1;
      return 1'b1;
    end
    if (fpos == 2'd1) begin
      if (c == CH_SPACE) begin
        fpos = 2'd2;
        return 1'b1;
      end
      return push_digit(c);
    end
    return 1'b1;
  endfunction

  function automatic bit list_char(logic [7:0] c);
    if (lstart && c == CH_DOT) begin
      dotl = 1'b1;
      return 1'b1;
    end
    if (dotl) return 1'b0;
    if (fpos == 2'd0) begin
      if (c == CH_SPACE) fpos = 2'd1;
      return 1'b1;
    end
    if (eff_mode() == MODE_SIZE) return push_digit(c);
    add_result(KIND_IDBYTE, {24'b0, c}, 1'b0);
    return 1'b1;
  endfunction

  function automatic void on_status(logic [7:0] c);
    logic [2:0] m;
    bit         more;
    bit         keep_pos;
    m    = eff_mode();
    slen = slen + 10'd1;
    if (slen == 10'd1) pos = (c == CH_PLUS);
    if (cr && c == CH_LF) begin
      more = pos && (m >= MODE_SIZE);
      if (m == MODE_COUNT && pos && fpos == 2'd0) begin
        flag_error(1'b1);
        return;
      end
      add_result(KIND_STATUS, (m == MODE_COUNT && pos) ? acc : 32'd0, !more);
      keep_pos = pos;
      clear_all_st();
      if (more) begin
        pos = keep_pos;
        ph  = PH_BODY;
      end
      return;
    end
    // CR not followed by LF counts as an ordinary byte
    if (cr) begin
      cr = 1'b0;
      if (!status_char(CH_CR)) begin
        flag_error(1'b0);
        cr = (c == CH_CR);
        return;
      end
    end
    if (c == CH_CR) cr = 1'b1;
    else if (!status_char(c)) begin
      flag_error(1'b0);
      return;
    end
    if (slen >= MAX_STATUS_LEN) flag_error(1'b0);
  endfunction

  function automatic void on_list(logic [7:0] c);
    if (cr && c == CH_LF) begin
      if (dotl) begin
        add_result(KIND_STATUS, '0, 1'b1);
        clear_all_st();
      end else if (fpos == 2'd0) begin
        flag_error(1'b1);
      end else begin
        if (eff_mode() == MODE_SIZE) add_result(KIND_SIZE, acc, 1'b0);
        else add_result(KIND_IDEND, '0, 1'b0);
        clear_line_st();
      end
      return;
    end
    if (cr) begin
      cr = 1'b0;
      if (!list_char(CH_CR)) begin
        flag_error(1'b0);
        cr = (c == CH_CR);
        return;
      end
    end
    if (c == CH_CR) cr = 1'b1;
    else if (!list_char(c)) begin
      flag_error(1'b0);
      return;
    end
    lstart = 1'b0;
  endfunction

  function automatic void on_message(logic [7:0] c);
    if (held == 2'd1) begin
      if (c == CH_CR) begin
        held = 2'd2;
        return;
      end
      add_result(KIND_MSG, {24'b0, CH_DOT}, 1'b0);
      held = 2'd0;
      dotl = 1'b0;
    end else if (held == 2'd2) begin
      if (c == CH_LF) begin
        add_result(KIND_STATUS, '0, 1'b1);
        clear_all_st();
        return;
      end
      // not the closing line: release the held ".\r" first
      add_result(KIND_MSG, {24'b0, CH_DOT}, 1'b0);
      add_result(KIND_MSG, {24'b0, CH_CR}, 1'b0);
      held = 2'd0;
      dotl = 1'b0;
      cr   = 1'b0;
    end else if (lstart && c == CH_DOT) begin
      held   = 2'd1;
      dotl   = 1'b1;
      lstart = 1'b0;
      return;
    end
    add_result(KIND_MSG, {24'b0, c}, 1'b0);
    if (cr && c == CH_LF) begin
      cr     = 1'b0;
      lstart = 1'b1;
    end else begin
      cr     = (c == CH_CR);
      lstart = 1'b0;
    end
  endfunction

  function automatic void parse_byte(logic [7:0] c);
    logic [2:0] m;
    m = eff_mode();
    if (ph == PH_STATUS) begin
      on_status(c);
    end else if (ph == PH_DRAIN) begin
      if (cr && c == CH_LF) clear_all_st();
      else cr = (c == CH_CR);
    end else if (m == MODE_SIZE || m == MODE_ID) begin
      on_list(c);
    end else if (m == MODE_MSG) begin
      on_message(c);
    end else begin
      clear_all_st();
    end
  endfunction

  initial begin
    mode_reg = MODE_STATUS;
    clear_all_st();
  end

  // ---------------------------------------------------------------------------
  // Byte source
  // ---------------------------------------------------------------------------
  logic [7:0] tx_q[$];
  int         bytes_made = 0;
  int         tx_gap = 0;
  bit         idle_on = 1'b1;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) parse_byte(s_tdata);
      if (s_tvalid && !s_tready) begin
        // request still pending, keep it on the bus
      end else if (tx_gap != 0) begin
        tx_gap   = tx_gap - 1;
        s_tvalid <= 1'b0;
      end else if (tx_q.size() == 0) begin
        s_tvalid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        tx_gap   = $urandom_range(0, 10);
        s_tvalid <= 1'b0;
      end else begin
        s_tvalid <= 1'b1;
        s_tdata  <= tx_q.pop_front();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result sink and checker
  // ---------------------------------------------------------------------------
  int errors = 0;
  int rx_wait = 0;
  bit rx_hold_req = 1'b0;

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp);
    errors++;
    $display("%0t: %s got %0h, expected %0h", $time, what, got, exp);
  endtask

  task automatic check_result();
    result_t exp;
    if (pending_results.size() == 0) begin
      report_mismatch("unexpected result, kind", {29'b0, m_tuser}, '0);
      return;
    end
    exp = pending_results.pop_front();
    if (m_tuser !== exp.kind) report_mismatch("kind", {29'b0, m_tuser}, {29'b0, exp.kind});
    if (m_tdata[31:0] !== exp.value) report_mismatch("value", m_tdata[31:0], exp.value);
    if (m_tdata[32] !== exp.status_ok)
      report_mismatch("status_ok", {31'b0, m_tdata[32]}, {31'b0, exp.status_ok});
    if (m_tlast !== exp.last) report_mismatch("last", {31'b0, m_tlast}, {31'b0, exp.last});
    if (m_tdata[39:33] !== 7'b0) report_mismatch("tdata padding", {25'b0, m_tdata[39:33]}, '0);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) check_result();
      if (rx_wait != 0) begin
        rx_wait  = rx_wait - 1;
        m_tready <= 1'b0;
      end else if (rx_hold_req) begin
        // long back-pressure so the result queue fills and input stalls
        rx_hold_req = 1'b0;
        rx_wait     = 149;
        m_tready    <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        rx_wait  = $urandom_range(0, 10);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Response builders
  // ---------------------------------------------------------------------------
  function automatic void put_ch(logic [7:0] c);
    tx_q.insert(tx_q.size(), c);
    bytes_made++;
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) put_ch(s[i]);
  endfunction

  function automatic void put_eol();
    put_ch(CH_CR);
    put_ch(CH_LF);
  endfunction

  function automatic void put_line(string s);
    put_text(s);
    put_eol();
  endfunction

  function automatic void put_num(logic [31:0] v);
    put_text($sformatf("%0d", v));
  endfunction

  function automatic void put_word(int n);
    for (int i = 0; i < n; i++) put_ch(8'($urandom_range(33, 126)));
  endfunction

  function automatic void put_noise(int n);
    for (int i = 0; i < n; i++) put_ch(8'($urandom_range(0, 255)));
  endfunction

  function automatic bit gen_status(logic [2:0] m);
    bit ok;
    int v;
    ok = ($urandom_range(0, 4) != 0);
    if (ok) put_text("+OK");
    else put_text("-ERR");
    if (m == MODE_COUNT) begin
      v = $urandom_range(0, 9);
      case (v)
        0: ;
        1: put_text(" 12x4 9");
        2: begin
          if ($urandom_range(0, 1) == 0) put_text(" 4294967296");
          else put_text(" 99999999999");
        end
        3: put_text(" 4294967295 1");
        4: begin
          put_text(" 7");
          put_ch(CH_CR);
          put_text("x");
        end
        default: begin
          put_ch(CH_SPACE);
          put_num(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 999));
          put_ch(CH_SPACE);
          put_num($urandom_range(0, 99999));
        end
      endcase
    end else if ($urandom_range(0, 1) == 0) begin
      put_ch(CH_SPACE);
      put_word($urandom_range(1, 8));
      if ($urandom_range(0, 5) == 0) begin
        put_ch(CH_CR);
        put_word(1);
      end
    end
    put_eol();
    return ok;
  endfunction

  function automatic void gen_list_body(logic [2:0] m);
    int n;
    int v;
    n = $urandom_range(0, 4);
    for (int i = 0; i < n; i++) begin
      v = $urandom_range(0, 15);
      case (v)
        0: put_noise($urandom_range(1, 6));
        1: put_text(".5 7");
        2: put_num(i + 1);
        3: begin
          put_num(i + 1);
          put_ch(CH_SPACE);
          if (m == MODE_SIZE) put_text("4294967295");
          else put_text("Q");
        end
        default: begin
          put_num(i + 1);
          put_ch(CH_SPACE);
          if (m == MODE_SIZE) put_num(($urandom_range(0, 7) == 0) ? $urandom :
                                      $urandom_range(0, 200000));
          else put_word($urandom_range(1, 8));
        end
      endcase
      put_eol();
    end
    if ($urandom_range(0, 9) != 0) put_line(".");
  endfunction

  function automatic void gen_message(int n);
    int v;
    for (int i = 0; i < n; i++) begin
      v = $urandom_range(0, 9);
      case (v)
        0: put_text(".");
        1: begin
          put_text(".");
          put_ch(CH_CR);
          put_word($urandom_range(1, 3));
        end
        2: put_text("..");
        3: begin
          put_word($urandom_range(0, 3));
          put_ch(CH_CR);
          put_word($urandom_range(1, 3));
        end
        4: put_noise($urandom_range(1, 6));
        default: ;
      endcase
      put_word($urandom_range(0, 6));
      put_eol();
    end
    put_line(".");
  endfunction

  function automatic void gen_response(logic [2:0] m);
    bit         ok;
    logic [2:0] em;
    em = (m > MODE_MSG) ? MODE_STATUS : m;
    if ($urandom_range(0, 7) == 0) put_noise($urandom_range(1, 4));
    ok = gen_status(em);
    if (ok && (em == MODE_SIZE || em == MODE_ID)) gen_list_body(em);
    else if (ok && em == MODE_MSG) gen_message($urandom_range(0, 4));
  endfunction

  // ---------------------------------------------------------------------------
  // Sequencing
  // ---------------------------------------------------------------------------
  // sender holds back until every request went out and all results are back
  task automatic settle();
    @(negedge clk);
    while (tx_q.size() != 0 || s_tvalid || pending_results.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_mode(logic [2:0] m);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    mode_reg = m;
    clear_all_st();
    @(negedge clk);
  endtask

  initial begin
    #3_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int         base;
    logic [2:0] m;
    int         n;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // status only, straight after reset
    put_line("+OK ready");
    put_line("-ERR no");
    // status line that never ends before the length limit
    put_ch(CH_PLUS);
    for (int i = 0; i < 520; i++) put_ch("a");
    put_eol();
    put_line("+OK");
    settle();

    write_mode(MODE_COUNT);
    put_line("+OK 2 320");
    put_line("+OK 4294967295");
    put_line("+OK 4294967296");
    put_line("+OK");
    put_line("+OK 1a 5");
    put_line("-ERR 5");
    put_line("+OK 0");
    put_ch(8'hFF);
    put_eol();
    settle();

    write_mode(MODE_SIZE);
    put_line("+OK");
    put_line("1 120");
    put_line("2 0");
    put_line(".");
    put_line("+OK");
    put_line("1 12x");
    put_line("+OK");
    put_line(".5 1");
    put_line("+OK");
    put_line("3");
    put_line("-ERR none");
    settle();

    write_mode(MODE_ID);
    put_line("+OK");
    put_line("1 ab");
    put_line("2 c");
    put_line(".");
    settle();

    write_mode(MODE_MSG);
    put_line("+OK");
    put_line("hi");
    put_line("..x");
    put_text(".");
    put_ch(CH_CR);
    put_line("A");
    put_line(".");
    settle();

    write_mode(3'd7);
    put_line("+OK 3");
    put_line("body");
    settle();

    // message body against a long receiver stall
    write_mode(MODE_MSG);
    rx_hold_req = 1'b1;
    put_line("+OK");
    for (int i = 0; i < 5; i++) put_line("message body line");
    put_line(".");
    settle();

    base = bytes_made;
    while (bytes_made - base < 150) begin
      idle_on = (bytes_made - base < 110) ? ($urandom_range(0, 3) != 0) : 1'b0;
      n = $urandom_range(0, 9);
      if (n < 2) m = 3'($urandom_range(0, 7));
      else if (n < 4) m = MODE_SIZE;
      else if (n < 6) m = MODE_ID;
      else if (n < 8) m = MODE_MSG;
      else m = MODE_COUNT;
      write_mode(m);
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) gen_response(m);
      settle();
    end

    settle();
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/pop3rp_pkg.sv
hdl/pop3_response_parser.sv
test/tb_top.sv
